>>> design/hse_pkg.sv
// Shared types and constants for the HDLC stuffing NRZI tone encoder.
`default_nettype none

package hse_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] RUN_LIMIT_RESET = 3'd5;
  localparam logic [2:0] MIN_LIMIT       = 3'd4;
  localparam logic       LINE_TONE_RESET = 1'b1;  // space tone

  // One queued byte, classified by the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stuff;
  } hse_entry_t;

  // Head of the byte queue as seen by the back end.
  typedef struct packed {
    logic       valid;
    hse_entry_t entry;
  } hse_qhead_t;

endpackage

`default_nettype wire

>>> design/hse_ifs.sv
// Valid/ready channel interfaces for byte input and bit-period output.
`default_nettype none

interface hse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       no_stuff;

  modport source (output valid, output data_byte, output no_stuff, input ready);
  modport sink   (input valid, input data_byte, input no_stuff, output ready);
endinterface

interface hse_out_if;
  logic valid;
  logic ready;
  logic tone;
  logic inserted;
  logic last_bit;

  modport source (output valid, output tone, output inserted, output last_bit, input ready);
  modport sink   (input valid, input tone, input inserted, input last_bit, output ready);
endinterface

`default_nettype wire

>>> design/hse_front.sv
// Front end: accepts bytes, classifies them and holds them in a small queue.
`default_nettype none

module hse_front
  import hse_pkg::*;
#(
  parameter int unsigned QDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  hse_in_if.sink     in_ch,
  input  logic       pop,
  output hse_qhead_t head
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  hse_entry_t         slots [QDepth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;
  logic               push;
  logic               do_pop;
  hse_entry_t         new_entry;

  assign in_ch.ready = (count != CntW'(QDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (count != '0);

  always_comb begin
    new_entry.data_byte = in_ch.data_byte;
    new_entry.stuff     = ~in_ch.no_stuff;
  end

  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QDepth))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (pop && count == '0) |=> (count == $past(count) + CntW'($past(push))))
    else $error("pop from empty queue changed count");

endmodule

`default_nettype wire

>>> design/hse_back.sv
// Back end: serializes queued bytes into NRZI bit periods with zero insertion.
`default_nettype none

module hse_back
  import hse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  hse_qhead_t head,
  output logic       pop,
  hse_out_if.source  out_ch
);

  logic [2:0] run_limit;
  logic       line_tone;
  logic [2:0] ones_run;
  logic       busy;
  logic [7:0] shreg;
  logic [2:0] bit_idx;
  logic       stuff;
  logic       pend_ins;
  logic       pend_last;
  logic       out_valid;
  logic       out_tone;
  logic       out_ins;
  logic       out_last;

  logic       step;
  logic [2:0] eff_lim;
  logic [7:0] cur_data;
  logic       cur_stuff;
  logic [2:0] cur_idx;
  logic       cur_bit;
  logic [2:0] run_inc;
  logic       hit;
  logic       is_end;

  assign step      = (!out_valid || out_ch.ready) && (pend_ins || busy || head.valid);
  assign eff_lim   = (run_limit < MIN_LIMIT) ? MIN_LIMIT : run_limit;
  assign cur_data  = busy ? shreg : head.entry.data_byte;
  assign cur_stuff = busy ? stuff : head.entry.stuff;
  assign cur_idx   = busy ? bit_idx : 3'd0;
  assign cur_bit   = cur_data[0];
  assign run_inc   = ones_run + 3'd1;
  assign hit       = cur_stuff && cur_bit && (run_inc >= eff_lim);
  assign is_end    = (cur_idx == 3'd7);
  // first bit of a new byte is registered for output in the same cycle it leaves the queue
  assign pop       = step && !pend_ins && !busy;

  assign out_ch.valid    = out_valid;
  assign out_ch.tone     = out_tone;
  assign out_ch.inserted = out_ins;
  assign out_ch.last_bit = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_limit <= RUN_LIMIT_RESET;
      line_tone <= LINE_TONE_RESET;
      ones_run  <= '0;
      busy      <= 1'b0;
      pend_ins  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        run_limit <= cfg_data;
      end
      if (step) begin
        out_valid <= 1'b1;
        if (pend_ins) begin
          // stuffed zero: toggle and report
          line_tone <= ~line_tone;
          out_tone  <= ~line_tone;
          out_ins   <= 1'b1;
          out_last  <= pend_last;
          pend_ins  <= 1'b0;
        end else begin
          out_ins <= 1'b0;
          if (!cur_bit) begin
            line_tone <= ~line_tone;
            out_tone  <= ~line_tone;
            ones_run  <= '0;
          end else begin
            out_tone <= line_tone;
            if (cur_stuff) begin
              ones_run <= hit ? 3'd0 : run_inc;
            end
          end
          pend_ins  <= hit;
          pend_last <= is_end;
          out_last  <= is_end && !hit;
          shreg     <= cur_data >> 1;
          stuff     <= cur_stuff;
          bit_idx   <= cur_idx + 3'd1;
          busy      <= !is_end;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_ins_clears_run: assert property (@(posedge clk) disable iff (rst)
    pend_ins |-> (ones_run == 3'd0))
    else $error("insert pending with nonzero run count");

  a_ins_one_period: assert property (@(posedge clk) disable iff (rst)
    (step && pend_ins) |=> (!pend_ins && out_ins))
    else $error("stuffed zero not emitted in one period");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!busy && !pend_ins && head.valid))
    else $error("queue popped while a byte is in progress");

endmodule

`default_nettype wire

>>> design/hdlc_stuffing_nrzi_tone_encoder_top.sv
// Top level of the HDLC bit-stuffing NRZI tone encoder.
//
//  channel   dir  payload                        transaction
//  in_ch     in   data_byte[7:0], no_stuff       valid & ready
//  out_ch    out  tone, inserted, last_bit       valid & ready
//  cfg       in   cfg_data[2:0] (run_limit)      cfg_we
//
// One bit period leaves per cycle while out_ch is not stalled: the serializer in the
// back end walks one data bit or one stuffed zero a cycle.
// A byte queue (QDepth entries) lets bytes be accepted while the back end works.
// rst (synchronous) empties the queue, sets run_limit to 5, tone to space, run to 0.
// A stall on out_ch holds the output register; the queue fills, then in_ch.ready drops.
`default_nettype none

module hdlc_stuffing_nrzi_tone_encoder_top
  import hse_pkg::*;
#(
  parameter int unsigned QDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  hse_in_if.sink     in_ch,
  hse_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data
);

  hse_qhead_t head;
  logic       pop;

  hse_front #(
    .QDepth(QDepth)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  hse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
